@@ src/yccrgb_pkg.sv @@
package yccrgb_pkg;

  // channel sums are signed with 16 fraction bits
  localparam int SUM_W = 28;
  localparam int FRAC_W = 16;

  localparam int K_CR_R  = 91881;
  localparam int K_OFF_R = 11701453;
  localparam int K_CB_G  = 22487;
  localparam int K_CR_G  = 46802;
  localparam int K_OFF_G = 8842818;
  localparam int K_CB_B  = 116130;
  localparam int K_OFF_B = 14806548;

  // restoring divide of the re-premultiply, two quotient bits per stage
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = 8 / DIV_BITS;

  // one sum stage, then clamp, divide stages, multiply and the divide by 255
  localparam int PIPE_DEPTH = 1 + 1 + DIV_STAGES + 2;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [7:0]              byp;
    logic [7:0]              alpha;
    logic                    mode;
  } chan_in_t;

endpackage

@@ src/yccrgb_chan.sv @@
module yccrgb_chan import yccrgb_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  chan_in_t   chan_i,
  output logic [7:0] chan_o,
  output logic [7:0] alpha_o,
  output logic       mode_o
);

  // clamp, invert and scale by 255
  logic [7:0]  clamp_v;
  logic [7:0]  inv_v;
  logic [15:0] num_v;
  logic        sat_v;

  always_comb begin
    if (chan_i.sum[SUM_W-1]) begin
      clamp_v = 8'd0;
    end else if (|chan_i.sum[SUM_W-2:FRAC_W+8]) begin
      clamp_v = 8'd255;
    end else begin
      clamp_v = chan_i.sum[FRAC_W+7:FRAC_W];
    end
    inv_v = 8'd255 - clamp_v;
    num_v = {inv_v, 8'b0} - {8'b0, inv_v};
    // quotient would reach 256: clamps to 255, also covers alpha of zero
    sat_v = (num_v >= {chan_i.alpha, 8'b0});
  end

  logic [15:0] rem_q   [DIV_STAGES+1];
  logic [7:0]  quo_q   [DIV_STAGES+1];
  logic [7:0]  alpha_q [DIV_STAGES+1];
  logic        sat_q   [DIV_STAGES+1];
  logic        mode_q  [DIV_STAGES+1];
  logic [7:0]  byp_q   [DIV_STAGES+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]   <= num_v;
      quo_q[0]   <= 8'd0;
      alpha_q[0] <= chan_i.alpha;
      sat_q[0]   <= sat_v;
      mode_q[0]  <= chan_i.mode;
      byp_q[0]   <= chan_i.byp;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    localparam int ShHi = 8 - DIV_BITS * k - 1;
    localparam int ShLo = ShHi - 1;

    logic [15:0] div_hi;
    logic [15:0] div_lo;
    logic [15:0] rem_mid;
    logic [15:0] rem_nxt;
    logic        bit_hi;
    logic        bit_lo;

    always_comb begin
      div_hi  = {8'b0, alpha_q[k]} << ShHi;
      div_lo  = {8'b0, alpha_q[k]} << ShLo;
      bit_hi  = (rem_q[k] >= div_hi);
      rem_mid = bit_hi ? (rem_q[k] - div_hi) : rem_q[k];
      bit_lo  = (rem_mid >= div_lo);
      rem_nxt = bit_lo ? (rem_mid - div_lo) : rem_mid;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]   <= rem_nxt;
        quo_q[k+1]   <= quo_q[k] | ({6'b0, bit_hi, bit_lo} << ShLo);
        alpha_q[k+1] <= alpha_q[k];
        sat_q[k+1]   <= sat_q[k];
        mode_q[k+1]  <= mode_q[k];
        byp_q[k+1]   <= byp_q[k];
      end
    end
  end

  // multiply back by alpha, with the rounding offset of the divide by 255
  logic [7:0]  quo_eff;
  logic [15:0] prod_q;
  logic [7:0]  alpha_m_q;
  logic        mode_m_q;
  logic [7:0]  byp_m_q;

  assign quo_eff = sat_q[DIV_STAGES] ? 8'd255 : quo_q[DIV_STAGES];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= (16'(quo_eff) * 16'(alpha_q[DIV_STAGES])) + 16'd127;
      alpha_m_q <= alpha_q[DIV_STAGES];
      mode_m_q  <= mode_q[DIV_STAGES];
      byp_m_q   <= byp_q[DIV_STAGES];
    end
  end

  // x / 255 as x / 256 plus one correction, since x - 255*t = x[7:0] + t
  logic [7:0] tq;
  logic [8:0] rr;
  logic [7:0] res;
  logic [7:0] chan_q;
  logic [7:0] alpha_o_q;
  logic       mode_o_q;

  always_comb begin
    tq  = prod_q[15:8];
    rr  = {1'b0, prod_q[7:0]} + {1'b0, tq};
    res = (rr >= 9'd255) ? (tq + 8'd1) : tq;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chan_q    <= mode_m_q ? res : byp_m_q;
      alpha_o_q <= alpha_m_q;
      mode_o_q  <= mode_m_q;
    end
  end

  assign chan_o  = chan_q;
  assign alpha_o = alpha_o_q;
  assign mode_o  = mode_o_q;

endmodule

@@ src/ycc_to_rgb_premultiply_fix.sv @@
// an accepted input word passes the sum, clamp, divide, multiply and divide-by-255 registers in order
// throughput: one pixel per clock while the output is not held; up to 8 pixels in flight
// a held output word stalls the whole pipeline, nothing is dropped or repeated
// reset clears all valid bits and sets opacity mode off (pass-through)
// pixel payload registers are not reset
module ycc_to_rgb_premultiply_fix import yccrgb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // opacity_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // luma, chroma_blue, chroma_red, alpha_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // red, green, blue, alpha_out
);

  logic opacity_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      opacity_mode_q <= cfg_wdata_i;
    end
  end

  logic [PIPE_DEPTH-1:0] vld_q;
  logic [PIPE_DEPTH-1:0] vld_d;
  logic                  adv;

  assign adv           = !vld_q[PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign vld_d         = {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // channel sums
  logic [7:0]       luma, cb, cr, alpha;
  logic [SUM_W-1:0] ys;
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;

  always_comb begin
    luma  = s_axis_tdata[7:0];
    cb    = s_axis_tdata[15:8];
    cr    = s_axis_tdata[23:16];
    alpha = s_axis_tdata[31:24];
    ys    = SUM_W'({luma, 16'b0});
    sum_r = ys + SUM_W'(K_CR_R) * SUM_W'(cr) - SUM_W'(K_OFF_R);
    sum_g = ys - SUM_W'(K_CB_G) * SUM_W'(cb) - SUM_W'(K_CR_G) * SUM_W'(cr)
          + SUM_W'(K_OFF_G);
    sum_b = ys + SUM_W'(K_CB_B) * SUM_W'(cb) - SUM_W'(K_OFF_B);
  end

  chan_in_t chan_r_q, chan_g_q, chan_b_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      chan_r_q <= '{sum: $signed(sum_r), byp: luma, alpha: alpha, mode: opacity_mode_q};
      chan_g_q <= '{sum: $signed(sum_g), byp: cb, alpha: alpha, mode: opacity_mode_q};
      chan_b_q <= '{sum: $signed(sum_b), byp: cr, alpha: alpha, mode: opacity_mode_q};
    end
  end

  logic [7:0] red, green, blue, alpha_out;
  logic [7:0] alpha_g, alpha_b;
  logic       mode_r, mode_g, mode_b;

  yccrgb_chan u_chan_r (
    .clk_i   (clk_i),
    .en_i    (adv),
    .chan_i  (chan_r_q),
    .chan_o  (red),
    .alpha_o (alpha_out),
    .mode_o  (mode_r)
  );

  yccrgb_chan u_chan_g (
    .clk_i   (clk_i),
    .en_i    (adv),
    .chan_i  (chan_g_q),
    .chan_o  (green),
    .alpha_o (alpha_g),
    .mode_o  (mode_g)
  );

  yccrgb_chan u_chan_b (
    .clk_i   (clk_i),
    .en_i    (adv),
    .chan_i  (chan_b_q),
    .chan_o  (blue),
    .alpha_o (alpha_b),
    .mode_o  (mode_b)
  );

  assign m_axis_tvalid = vld_q[PIPE_DEPTH-1];
  assign m_axis_tdata  = {alpha_out, blue, green, red};

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted word did not enter the pipeline");

  a_valid_from_prev : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld_q[PIPE_DEPTH-2]))
    else $error("output valid without a word in the stage before");

  a_transparent_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && mode_r && (m_axis_tdata[31:24] == 8'd0))
    |-> (m_axis_tdata[23:0] == 24'd0))
    else $error("transparent pixel gave nonzero color");

  a_lanes_agree : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((mode_g == mode_r) && (mode_b == mode_r)
                       && (alpha_g == alpha_out) && (alpha_b == alpha_out)))
    else $error("channel lanes out of step");

endmodule
